>>> design/sbcp_pkg.sv
// Shared types and constants for the start-byte checksum frame parser.
// No dependencies; every other design file refers to this package by scoped names.

package sbcp_pkg;

    // Input item kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result event codes
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_ACCEPT   = 2'd1,
        EV_MISMATCH = 2'd2,
        EV_TIMEOUT  = 2'd3
    } event_t;

    // Configuration register indexes (byte address = 4 * index)
    localparam int          CFG_ADDR_W   = 4;
    localparam logic [1:0]  REG_START    = 2'd0;
    localparam logic [1:0]  REG_TIMEOUT  = 2'd1;
    localparam logic [1:0]  REG_WINDOW   = 2'd2;

    // Register reset values
    localparam logic [7:0]  START_RESET   = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [23:0] WINDOW_RESET  = 24'd1000000;

    // Saturation limits of the counters
    localparam logic [15:0] GAP_MAX = 16'hFFFF;
    localparam logic [23:0] AGE_MAX = 24'hFFFFFF;

    // One input transfer
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    // One output transfer
    typedef struct packed {
        logic [1:0]        event_res;
        logic signed [7:0] steer_angle;
        logic [7:0]        throttle_level;
        logic [7:0]        button_bits;
        logic              link_valid;
    } result_t;

    // Configuration as seen by the parser core
    typedef struct packed {
        logic [7:0]  start_value;
        logic [15:0] byte_timeout;
        logic [23:0] valid_window;
    } cfg_t;

endpackage

>>> design/sbcp_apb.sv
// APB-style configuration register file for the frame parser.
// Depends on sbcp_pkg for the register indexes, reset values and cfg_t.

module sbcp_apb
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbcp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sbcp_pkg::cfg_t               cfg
);

    logic [7:0]  start_value_reg;
    logic [15:0] byte_timeout_reg;
    logic [23:0] valid_window_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg  <= sbcp_pkg::START_RESET;
            byte_timeout_reg <= sbcp_pkg::TIMEOUT_RESET;
            valid_window_reg <= sbcp_pkg::WINDOW_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sbcp_pkg::REG_START:   start_value_reg  <= pwdata[7:0];
                sbcp_pkg::REG_TIMEOUT: byte_timeout_reg <= pwdata[15:0];
                sbcp_pkg::REG_WINDOW:  valid_window_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            sbcp_pkg::REG_START:   prdata = {24'd0, start_value_reg};
            sbcp_pkg::REG_TIMEOUT: prdata = {16'd0, byte_timeout_reg};
            sbcp_pkg::REG_WINDOW:  prdata = {8'd0, valid_window_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg.start_value  = start_value_reg;
    assign cfg.byte_timeout = byte_timeout_reg;
    assign cfg.valid_window = valid_window_reg;

endmodule

>>> design/sbcp_core.sv
// Parser state and combinational step logic: framing, checksum, timeouts, link age.
// Depends on sbcp_pkg for item_t, result_t, cfg_t and the event codes.

module sbcp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sbcp_pkg::item_t   item,
    input  sbcp_pkg::cfg_t    cfg,
    output sbcp_pkg::result_t result
);

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_STEER = 5'b00010,
        PH_THROT = 5'b00100,
        PH_BTN   = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [15:0]      gap_count_reg, gap_count_next;
    logic [23:0]      age_count_reg, age_count_next;
    logic [7:0]       frame_reg [3];
    logic [7:0]       frame_next [3];
    logic [7:0]       pub_reg [3];
    logic [7:0]       pub_next [3];
    logic [15:0]      gap_inc;
    logic [7:0]       byte_sum;
    sbcp_pkg::event_t ev;

    assign byte_sum = frame_reg[0] + frame_reg[1] + frame_reg[2];
    assign gap_inc  = (gap_count_reg == sbcp_pkg::GAP_MAX) ? gap_count_reg
                                                           : gap_count_reg + 16'd1;

    // Step for one item
    always_comb
    begin
        phase_next     = phase_reg;
        gap_count_next = gap_count_reg;
        age_count_next = age_count_reg;
        frame_next     = frame_reg;
        pub_next       = pub_reg;
        ev             = sbcp_pkg::EV_NONE;

        if (item.mode == sbcp_pkg::MODE_BYTE)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (item.rx_byte == cfg.start_value)
                    begin
                        phase_next     = PH_STEER;
                        gap_count_next = 16'd0;
                    end
                end
                PH_STEER:
                begin
                    frame_next[0]  = item.rx_byte;
                    phase_next     = PH_THROT;
                    gap_count_next = 16'd0;
                end
                PH_THROT:
                begin
                    frame_next[1]  = item.rx_byte;
                    phase_next     = PH_BTN;
                    gap_count_next = 16'd0;
                end
                PH_BTN:
                begin
                    frame_next[2]  = item.rx_byte;
                    phase_next     = PH_CHECK;
                    gap_count_next = 16'd0;
                end
                PH_CHECK:
                begin
                    if (byte_sum == item.rx_byte)
                    begin
                        pub_next       = frame_reg;
                        age_count_next = 24'd0;
                        ev             = sbcp_pkg::EV_ACCEPT;
                    end
                    else
                    begin
                        ev = sbcp_pkg::EV_MISMATCH;
                    end
                    phase_next     = PH_HUNT;
                    gap_count_next = 16'd0;
                end
                default:
                begin
                    phase_next     = PH_HUNT;
                    gap_count_next = 16'd0;
                end
            endcase
        end
        else
        begin
            // Tick: age advances until it saturates, gap only inside a frame
            if (age_count_reg != sbcp_pkg::AGE_MAX)
            begin
                age_count_next = age_count_reg + 24'd1;
            end
            if (phase_reg != PH_HUNT)
            begin
                if (gap_inc >= cfg.byte_timeout)
                begin
                    phase_next     = PH_HUNT;
                    gap_count_next = 16'd0;
                    ev             = sbcp_pkg::EV_TIMEOUT;
                end
                else
                begin
                    gap_count_next = gap_inc;
                end
            end
        end
    end

    // Status of this item
    assign result.event_res      = ev;
    assign result.steer_angle    = pub_next[0];
    assign result.throttle_level = pub_next[1];
    assign result.button_bits    = pub_next[2];
    assign result.link_valid     = (age_count_next < cfg.valid_window);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            gap_count_reg <= 16'd0;
            age_count_reg <= 24'd0;
            pub_reg[0]    <= 8'd0;
            pub_reg[1]    <= 8'd0;
            pub_reg[2]    <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            gap_count_reg <= gap_count_next;
            age_count_reg <= age_count_next;
            pub_reg       <= pub_next;
        end
    end

    // Frame payload bytes, written before read
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            frame_reg <= frame_next;
        end
    end

    // Gap counter only runs inside a frame
    a_gap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (gap_count_reg == 16'd0))
        else $error("gap count nonzero while hunting");

    // Accepted frame restarts the link age
    a_accept_age: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ev == sbcp_pkg::EV_ACCEPT) |=> (age_count_reg == 24'd0))
        else $error("age not cleared after accepted frame");

    // Any event ends the frame
    a_event_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ev != sbcp_pkg::EV_NONE) |=> (phase_reg == PH_HUNT))
        else $error("parser not hunting after frame event");

endmodule

>>> design/start_byte_checksum_frame_parser.sv
// Top level of the start-byte checksum frame parser: input and result registers.
// Depends on sbcp_pkg, sbcp_apb and sbcp_core.

// Each input transfer is either a received UART byte or a one-microsecond tick, and
// each gives exactly one result transfer: the event of that item (none, frame
// accepted, checksum mismatch, inter-byte timeout), the last accepted steering,
// throttle and button bytes, and whether the link is still valid. An item passes from
// the input register through the core to the result register; one item is accepted
// every clock while out_stall stays low, and out_valid rises once the item has reached
// the result register. Registers (start byte at 0x0, byte timeout at 0x4, valid window
// at 0x8) must be written through the APB port only while the block is idle; the block
// itself does not enforce this. The link reads valid right after reset.

module start_byte_checksum_frame_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sbcp_pkg::item_t                 in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sbcp_pkg::result_t               out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbcp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    sbcp_pkg::cfg_t    cfg;
    sbcp_pkg::item_t   s1_item_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg;
    sbcp_pkg::result_t out_result_reg;
    sbcp_pkg::result_t core_result;
    logic              advance;
    logic              in_xfer;
    logic              fire;

    // Pipeline control
    assign advance       = !out_valid_reg || !out_stall;
    assign in_stall      = s1_valid_reg && !advance;
    assign in_xfer       = in_valid && !in_stall;
    assign fire          = s1_valid_reg && advance;
    assign s1_valid_next = in_xfer || (s1_valid_reg && !advance);

    sbcp_apb u_apb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbcp_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_result_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_result_reg;

    // A held item stays in the input register while the output is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("input register dropped an item under stall");

    // An item that moves on shows up as a result next cycle
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    // With an empty result register the input side never stalls
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty result register");

endmodule

>>> tb/tb_start_byte_checksum_frame_parser.sv
// Self-checking testbench for start_byte_checksum_frame_parser: byte/tick stimulus,
// an in-bench status predictor, result checking and APB register setup.
// Depends on sbcp_pkg and the start_byte_checksum_frame_parser RTL.
`timescale 1ns / 100ps

module tb_start_byte_checksum_frame_parser;

    localparam int IDLE_LIMIT = 4000;

    typedef enum int {PH_HUNT, PH_STEER, PH_THROTTLE, PH_BUTTONS, PH_SUM} phase_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_style_t;

    // DUT connections
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    sbcp_pkg::item_t                 in_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    sbcp_pkg::result_t               out_data;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [sbcp_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // Predictor state and its copy of the registers
    logic [7:0]  cfg_start = sbcp_pkg::START_RESET;
    logic [15:0] cfg_timeout = sbcp_pkg::TIMEOUT_RESET;
    logic [23:0] cfg_window = sbcp_pkg::WINDOW_RESET;
    phase_t      ph = PH_HUNT;
    logic [15:0] gap_ticks = '0;
    logic [23:0] age_ticks = '0;
    logic [7:0]  frame_buf [3] = '{8'h00, 8'h00, 8'h00};
    logic [7:0]  shown_buf [3] = '{8'h00, 8'h00, 8'h00};

    sbcp_pkg::result_t pending_status [$];
    int                errors = 0;
    int                useful_items = 0;
    int                burst_left = 0;
    bit                steady = 1'b0;
    int                idle_cycles = 0;

    start_byte_checksum_frame_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Status after one byte or tick; updates the predictor state
    function automatic sbcp_pkg::result_t track_frame(input sbcp_pkg::item_t it);
        sbcp_pkg::result_t r;
        sbcp_pkg::event_t  ev;
        logic [7:0]        sum;
        ev = sbcp_pkg::EV_NONE;
        if (it.mode == sbcp_pkg::MODE_BYTE)
        begin
            case (ph)
                PH_HUNT:
                begin
                    if (it.rx_byte == cfg_start)
                    begin
                        ph = PH_STEER;
                        gap_ticks = '0;
                    end
                end
                PH_STEER, PH_THROTTLE, PH_BUTTONS:
                begin
                    frame_buf[ph - PH_STEER] = it.rx_byte;
                    ph = phase_t'(ph + 1);
                    gap_ticks = '0;
                end
                default:
                begin
                    sum = frame_buf[0] + frame_buf[1] + frame_buf[2];
                    if (sum == it.rx_byte)
                    begin
                        shown_buf = frame_buf;
                        age_ticks = '0;
                        ev = sbcp_pkg::EV_ACCEPT;
                    end
                    else
                    begin
                        ev = sbcp_pkg::EV_MISMATCH;
                    end
                    ph = PH_HUNT;
                    gap_ticks = '0;
                end
            endcase
        end
        else
        begin
            if (age_ticks != sbcp_pkg::AGE_MAX)
                age_ticks = age_ticks + 1'b1;
            if (ph != PH_HUNT)
            begin
                if (gap_ticks != sbcp_pkg::GAP_MAX)
                    gap_ticks = gap_ticks + 1'b1;
                if (gap_ticks >= cfg_timeout)
                begin
                    ph = PH_HUNT;
                    gap_ticks = '0;
                    ev = sbcp_pkg::EV_TIMEOUT;
                end
            end
        end
        r.event_res      = ev;
        r.steer_angle    = shown_buf[0];
        r.throttle_level = shown_buf[1];
        r.button_bits    = shown_buf[2];
        r.link_valid     = (age_ticks < cfg_window);
        return r;
    endfunction

    // One input transfer; sender may idle between bursts of random length
    task automatic send_item(input logic mode, input logic [7:0] b);
        sbcp_pkg::item_t it;
        int              gap;
        it.mode    = mode;
        it.rx_byte = b;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0 || steady) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (!(ph == PH_HUNT && mode == sbcp_pkg::MODE_BYTE && b != cfg_start))
            useful_items++;
        pending_status.push_back(track_frame(it));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(sbcp_pkg::MODE_BYTE, b);
    endtask

    // Ticks carry a random, ignored byte
    task automatic send_ticks(input int n);
        repeat (n) send_item(sbcp_pkg::MODE_TICK, 8'($urandom));
    endtask

    // Start byte, payload and checksum; optionally ticks ahead of each byte
    task automatic send_frame(input logic [7:0] s, input logic [7:0] t, input logic [7:0] b,
                              input logic [7:0] chk, input bit gappy);
        logic [7:0] bytes [4];
        int         k;
        bytes = '{s, t, b, chk};
        send_byte(cfg_start);
        foreach (bytes[i])
        begin
            if (gappy)
            begin
                if (cfg_timeout > 64 || $urandom_range(0, 7) != 0)
                    k = $urandom_range(0, 2);
                else
                    k = $urandom_range(0, cfg_timeout + 1);
                send_ticks(k);
            end
            send_byte(bytes[i]);
        end
    endtask

    // Stop sending and wait until every expected status has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB setup and access phases; the register updates at the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            sbcp_pkg::REG_START:   cfg_start = value[7:0];
            sbcp_pkg::REG_TIMEOUT: cfg_timeout = value[15:0];
            default:               cfg_window = value[23:0];
        endcase
    endtask

    task automatic configure(input logic [7:0] sv, input logic [15:0] to,
                             input logic [23:0] win);
        drain_results();
        write_reg(sbcp_pkg::REG_START, {24'd0, sv});
        write_reg(sbcp_pkg::REG_TIMEOUT, {16'd0, to});
        write_reg(sbcp_pkg::REG_WINDOW, {8'd0, win});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hunting: non-start bytes dropped, ticks count age only
    task automatic test_hunting();
        send_item(sbcp_pkg::MODE_TICK, 8'hFF);
        send_item(sbcp_pkg::MODE_TICK, 8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h02);
    endtask

    // Accept, mismatch, start value as data, field extremes
    task automatic test_frames();
        send_frame(8'h80, 8'hFF, 8'h02, 8'h81, 1'b0);
        send_frame(sbcp_pkg::START_RESET, sbcp_pkg::START_RESET, sbcp_pkg::START_RESET,
                   8'h03, 1'b0);
        send_frame(8'h7F, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_frame(8'h7F, 8'hFE, 8'hFD, 8'h7A, 1'b0);
    endtask

    // Inter-byte timeout at small, zero, moderate and largest settings
    task automatic test_timeout();
        configure(sbcp_pkg::START_RESET, 16'd3, sbcp_pkg::WINDOW_RESET);
        send_byte(sbcp_pkg::START_RESET);
        send_byte(8'h10);
        send_ticks(3);
        send_byte(8'h20);
        configure(sbcp_pkg::START_RESET, 16'd0, sbcp_pkg::WINDOW_RESET);
        send_byte(sbcp_pkg::START_RESET);
        send_ticks(2);
        // just under the timeout between bytes
        configure(sbcp_pkg::START_RESET, 16'd40, sbcp_pkg::WINDOW_RESET);
        steady = 1'b1;
        send_byte(sbcp_pkg::START_RESET);
        send_ticks(39);
        send_byte(8'h11);
        send_ticks(39);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h66);
        configure(8'hFF, 16'hFFFF, sbcp_pkg::WINDOW_RESET);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_ticks(50);
        send_byte(8'h55);
        steady = 1'b0;
    endtask

    // Link validity: zero, one, short and largest windows
    task automatic test_link_window();
        configure(8'h00, sbcp_pkg::TIMEOUT_RESET, 24'd0);
        send_ticks(1);
        send_frame(8'h01, 8'h02, 8'h04, 8'h07, 1'b0);
        configure(8'h00, sbcp_pkg::TIMEOUT_RESET, 24'd1);
        send_frame(8'hC0, 8'h40, 8'hFE, 8'hFE, 1'b0);
        send_ticks(2);
        configure(8'h00, sbcp_pkg::TIMEOUT_RESET, 24'd5);
        send_frame(8'h05, 8'h06, 8'h07, 8'h12, 1'b0);
        send_ticks(7);
        configure(8'h00, sbcp_pkg::TIMEOUT_RESET, 24'hFFFFFF);
        send_ticks(3);
        send_frame(8'h81, 8'h01, 8'h00, 8'h82, 1'b0);
        send_ticks(3);
    endtask

    // Mostly well-formed frames with random content, plus truncated frames and noise
    task automatic test_random_traffic();
        logic [7:0] s, t, b, chk;
        logic [7:0] sv;
        logic [15:0] to;
        logic [23:0] win;
        int goal;
        for (int p = 0; p < 6; p++)
        begin
            sv  = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
            to  = (p == 2) ? 16'd1 : 16'($urandom_range(2, 24));
            win = (p == 3) ? 24'hFFFFFF : 24'($urandom_range(1, 150));
            configure(sv, to, win);
            steady = ($urandom_range(0, 3) == 0);
            goal = useful_items + 95;
            while (useful_items < goal)
            begin
                case ($urandom_range(0, 9))
                    7:
                    begin
                        send_byte(cfg_start);
                        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
                        send_ticks(cfg_timeout + $urandom_range(0, 2));
                    end
                    8, 9:
                    begin
                        repeat ($urandom_range(1, 5)) send_item(1'($urandom), 8'($urandom));
                    end
                    default:
                    begin
                        s = 8'($urandom);
                        t = 8'($urandom);
                        b = 8'($urandom);
                        chk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(s + t + b);
                        send_frame(s, t, b, chk, 1'b1);
                    end
                endcase
            end
        end
        steady = 1'b0;
    endtask

    // Receiver stall patterns: none, light, heavy, long runs
    stall_style_t stall_style = STALL_NONE;
    int           stall_style_left = 0;
    int           stall_run = 0;
    bit           stall_now = 1'b0;

    always @(posedge clk)
    begin
        if (stall_style_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_style_left = $urandom_range(50, 300);
        end
        stall_style_left--;
        if (stall_run == 0)
        begin
            case (stall_style)
                STALL_NONE:
                begin
                    stall_now = 1'b0;
                    stall_run = 1;
                end
                STALL_LIGHT:
                begin
                    stall_now = ($urandom_range(0, 3) == 0);
                    stall_run = 1;
                end
                STALL_HEAVY:
                begin
                    stall_now = ($urandom_range(0, 3) != 0);
                    stall_run = $urandom_range(1, 3);
                end
                default:
                begin
                    stall_now = !stall_now;
                    stall_run = stall_now ? $urandom_range(5, 30) : $urandom_range(1, 8);
                end
            endcase
        end
        stall_run--;
        out_stall <= stall_now;
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    // Compare each result transfer with the oldest expected status
    always @(posedge clk)
    begin
        sbcp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $error("result transfer with no expected status: %0h", out_data);
                errors++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("event_res", 8'(want.event_res), 8'(out_data.event_res));
                check_field("steer_angle", want.steer_angle, out_data.steer_angle);
                check_field("throttle_level", want.throttle_level, out_data.throttle_level);
                check_field("button_bits", want.button_bits, out_data.button_bits);
                check_field("link_valid", 8'(want.link_valid), 8'(out_data.link_valid));
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hunting();
        test_frames();
        test_timeout();
        test_link_window();
        test_random_traffic();
        drain_results();
        if (errors == 0 && pending_status.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
